FILE: hdl/nearest_neighbor_track_table_macros.svh
// Assertion macros for the track table.
`ifndef NEAREST_NEIGHBOR_TRACK_TABLE_MACROS_SVH
`define NEAREST_NEIGHBOR_TRACK_TABLE_MACROS_SVH
`define NNTT_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("nntt check failed");
`define NNTT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("nntt check failed");
`endif

FILE: hdl/nntt_pkg.sv
// Types and constants of the track table.
`default_nettype none
package nntt_pkg;
  localparam logic [1:0] KIND_DET = 2'd0;
  localparam logic [1:0] KIND_LIST = 2'd1;
  localparam logic [1:0] KIND_SUM = 2'd2;
  localparam logic [1:0] REG_GATE = 2'd0;
  localparam logic [1:0] REG_CONFIRM = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  typedef struct packed {
    logic        func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [13:0] size_in;
    logic [31:0] frame_time;
  } req_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] track_id;
    logic        is_new;
    logic        is_confirmed;
    logic        table_full;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [13:0] out_size;
    logic [6:0]  removed_count;
    logic [6:0]  live_count;
    logic        last;
  } req_out_t;

  typedef struct packed {
    logic        start;
  } dist_ctl_t;
endpackage
`default_nettype wire

FILE: hdl/nntt_dist.sv
// Shared squared-distance unit: one axis difference squared per cycle, accumulated.
`default_nettype none
module nntt_dist import nntt_pkg::*; (
  input  wire logic clk,
  input  wire dist_ctl_t ctl,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  output logic [34:0] acc
);
  logic signed [16:0] diff;
  logic [33:0] sqr;
  assign diff = 17'(a) - 17'(b);
  assign sqr = 34'(diff * diff);
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc <= 35'(sqr);
    end else begin
      acc <= acc + 35'(sqr);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/nearest_neighbor_track_table.sv
// Top level of the gated nearest-neighbor track table.
`default_nettype none
`include "nearest_neighbor_track_table_macros.svh"
// A detection scans the table with one shared squarer that handles one axis of one slot
// per cycle, skipping slots already matched this frame, then does the last distance
// compare, the decision and, on a match, the update. An end of frame compacts the table,
// then lists the confirmed remaining tracks and a summary, holding while a result waits
// on out_stall. The block takes one request at a time; in_stall is high while a request
// is in work or a result waits.
module nearest_neighbor_track_table import nntt_pkg::*; #(
  parameter int MAX_TRACKS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire req_in_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output req_out_t out_data,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [33:0] cfg_data
);
  localparam int IW = $clog2(MAX_TRACKS);
  localparam int CW = $clog2(MAX_TRACKS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DEC, S_UPD, S_COMP, S_LIST}
    state_t;
  state_t state;

  logic [33:0] gate;
  logic [7:0] confirm;
  logic [8:0] alpha;
  logic [15:0] tmo;

  logic signed [15:0] sx [MAX_TRACKS];
  logic signed [15:0] sy [MAX_TRACKS];
  logic signed [15:0] sz [MAX_TRACKS];
  logic [13:0] ssz [MAX_TRACKS];
  logic [31:0] sseen [MAX_TRACKS];
  logic [7:0] shits [MAX_TRACKS];
  logic sconf [MAX_TRACKS];
  logic [15:0] sid [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] smatch;
  logic [CW-1:0] occ, rd, wr, removed;
  logic [15:0] nid;

  req_in_t rq;
  logic [1:0] axis;
  logic pend;
  logic [IW-1:0] pidx, bidx;
  logic [34:0] best;
  logic found;
  logic [34:0] acc;
  dist_ctl_t dctl;
  logic signed [15:0] da, db;
  logic [IW-1:0] ri, wi;
  logic [31:0] age;
  logic [8:0] asat;
  logic [22:0] mix;
  logic [7:0] hnew;
  req_out_t res;
  logic res_load;

  assign ri = rd[IW-1:0];
  assign wi = wr[IW-1:0];
  assign dctl.start = (axis == 2'd0);
  always_comb begin
    unique case (axis)
      2'd0: begin da = rq.pos_x; db = sx[ri]; end
      2'd1: begin da = rq.pos_y; db = sy[ri]; end
      default: begin da = rq.pos_z; db = sz[ri]; end
    endcase
  end
  nntt_dist u_dist (.clk(clk), .ctl(dctl), .a(da), .b(db), .acc(acc));

  assign age = rq.frame_time - sseen[ri];
  assign asat = (alpha > 9'd256) ? 9'd256 : alpha;
  assign mix = 23'((9'd256 - asat) * ssz[bidx]) + 23'(asat * rq.size_in) + 23'd128;
  assign hnew = (shits[bidx] == 8'hFF) ? 8'hFF : shits[bidx] + 8'd1;
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    res = '0;
    res_load = 1'b0;
    unique case (state)
      S_DEC: begin
        res.kind = KIND_DET; res.last = 1'b1;
        if (found) begin
          res_load = 1'b0;
        end else if (occ >= CW'(MAX_TRACKS)) begin
          res.table_full = 1'b1; res_load = 1'b1;
        end else begin
          res.track_id = nid; res.is_new = 1'b1;
          res.is_confirmed = (confirm <= 8'd1);
          res.out_x = rq.pos_x; res.out_y = rq.pos_y;
          res.out_z = rq.pos_z; res.out_size = rq.size_in;
          res_load = 1'b1;
        end
      end
      S_UPD: begin
        res.kind = KIND_DET; res.last = 1'b1;
        res.track_id = sid[bidx];
        res.is_confirmed = sconf[bidx] || (hnew >= confirm);
        res.out_x = sx[bidx]; res.out_y = sy[bidx];
        res.out_z = sz[bidx]; res.out_size = mix[21:8];
        res_load = 1'b1;
      end
      S_LIST: begin
        if (!out_valid || !out_stall) begin
          if (rd < occ) begin
            if (sconf[ri]) begin
              res.kind = KIND_LIST; res.track_id = sid[ri];
              res.is_confirmed = 1'b1; res.out_x = sx[ri];
              res.out_y = sy[ri]; res.out_z = sz[ri];
              res.out_size = ssz[ri]; res_load = 1'b1;
            end
          end else begin
            res.kind = KIND_SUM; res.last = 1'b1;
            res.removed_count = 7'(removed); res.live_count = 7'(occ);
            res_load = 1'b1;
          end
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate <= 34'd250000; confirm <= 8'd3; alpha <= 9'd77; tmo <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GATE: gate <= cfg_data;
        REG_CONFIRM: confirm <= cfg_data[7:0];
        REG_ALPHA: alpha <= cfg_data[8:0];
        REG_TIMEOUT: tmo <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      smatch <= '0; occ <= '0; nid <= '0;
      rd <= '0; wr <= '0; removed <= '0; axis <= '0; pend <= 1'b0; found <= 1'b0;
      pidx <= '0; bidx <= '0; best <= '0;
    end else begin
      if (res_load) begin
        out_data <= res; out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            rq <= in_data; rd <= '0; wr <= '0; removed <= '0; axis <= '0;
            pend <= 1'b0; found <= 1'b0; best <= 35'(gate);
            state <= in_data.func ? S_COMP : S_SCAN;
          end
        end
        S_SCAN: begin
          // acc from previous slot is complete when axis wraps to 0
          if (pend && axis == 2'd0) begin
            pend <= 1'b0;
            if (acc < best) begin best <= acc; bidx <= pidx; found <= 1'b1; end
          end
          if (axis != 2'd0) begin
            axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
            if (axis == 2'd2) begin pend <= 1'b1; pidx <= ri; rd <= rd + 1'b1; end
          end else if (rd < occ && !smatch[ri]) begin
            axis <= 2'd1;
          end else if (rd < occ) begin
            rd <= rd + 1'b1;
          end else if (!pend) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (found) begin
            state <= S_UPD;
          end else if (occ >= CW'(MAX_TRACKS)) begin
            state <= S_IDLE;
          end else begin
            sid[occ[IW-1:0]] <= nid; nid <= nid + 16'd1;
            sx[occ[IW-1:0]] <= rq.pos_x; sy[occ[IW-1:0]] <= rq.pos_y;
            sz[occ[IW-1:0]] <= rq.pos_z; ssz[occ[IW-1:0]] <= rq.size_in;
            sseen[occ[IW-1:0]] <= rq.frame_time; shits[occ[IW-1:0]] <= 8'd1;
            sconf[occ[IW-1:0]] <= (confirm <= 8'd1); smatch[occ[IW-1:0]] <= 1'b1;
            occ <= occ + 1'b1;
            state <= S_IDLE;
          end
        end
        S_UPD: begin
          sseen[bidx] <= rq.frame_time; shits[bidx] <= hnew;
          sconf[bidx] <= sconf[bidx] || (hnew >= confirm);
          ssz[bidx] <= mix[21:8]; smatch[bidx] <= 1'b1;
          state <= S_IDLE;
        end
        S_COMP: begin
          if (rd < occ) begin
            if (age > 32'(tmo)) begin
              removed <= removed + 1'b1;
            end else begin
              sx[wi] <= sx[ri]; sy[wi] <= sy[ri]; sz[wi] <= sz[ri];
              ssz[wi] <= ssz[ri]; sseen[wi] <= sseen[ri]; shits[wi] <= shits[ri];
              sconf[wi] <= sconf[ri]; sid[wi] <= sid[ri];
              wr <= wr + 1'b1;
            end
            rd <= rd + 1'b1;
          end else begin
            occ <= wr; rd <= '0; smatch <= '0; state <= S_LIST;
          end
        end
        S_LIST: begin
          if (!out_valid || !out_stall) begin
            if (rd < occ) begin
              rd <= rd + 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NNTT_ASSERT_IMPL(a_occ_max, 1'b1, occ <= CW'(MAX_TRACKS))
  `NNTT_ASSERT_IMPL(a_stall_busy, state != S_IDLE, in_stall)
  `NNTT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
`default_nettype wire
